FILE: hdl/bpr_pkg.sv
// bpr_pkg: shared types and constants for the byte pattern replace block
// no dependencies; imported by every module of the block
`default_nettype none

package bpr_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int MAX_REPLACE = 8;
    localparam int CMD_DEPTH   = 2;

    // configuration register indexes
    localparam logic [1:0] REG_MATCH_LENGTH       = 2'd0;
    localparam logic [1:0] REG_MATCH_PATTERN      = 2'd1;
    localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd2;
    localparam logic [1:0] REG_REPLACEMENT_BYTES  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_out;
    } out_item_t;

    // one classified input byte: up to eight bytes to emit, in order
    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  n;
        logic        last;
    } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/bpr_front.sv
// bpr_front: configuration registers, sliding window and pattern compare
// depends on bpr_pkg; feeds emit commands into the command queue
`default_nettype none

module bpr_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wen,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [63:0]      cfg_data,
    input  wire logic             accept,
    input  wire bpr_pkg::in_item_t item,
    output logic                  cmd_push,
    output bpr_pkg::cmd_t         cmd
);
    import bpr_pkg::*;

    logic [3:0]  match_length_reg;
    logic [63:0] match_pattern_reg;
    logic [3:0]  replacement_length_reg;
    logic [63:0] replacement_bytes_reg;

    logic [63:0] window_reg, window_next;
    logic [2:0]  count_reg, count_next;

    logic [3:0]  len_eff;
    logic [3:0]  rlen_eff;
    logic [3:0]  count_inc;
    logic [63:0] w;
    logic        full_now;
    logic        hit;

    always_comb
    begin
        if (match_length_reg == 4'd0)
            len_eff = 4'd1;
        else if (match_length_reg > 4'(MAX_PATTERN))
            len_eff = 4'(MAX_PATTERN);
        else
            len_eff = match_length_reg;
        if (replacement_length_reg > 4'(MAX_REPLACE))
            rlen_eff = 4'(MAX_REPLACE);
        else
            rlen_eff = replacement_length_reg;
    end

    assign count_inc = {1'b0, count_reg} + 4'd1;
    assign full_now  = (count_inc == len_eff);

    // window with the new byte written at the fill position
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            if (3'(i) == count_reg)
                w[i*8 +: 8] = item.data_byte;
            else
                w[i*8 +: 8] = window_reg[i*8 +: 8];
        end
    end

    always_comb
    begin
        hit = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if ((4'(i) < len_eff) && (w[i*8 +: 8] != match_pattern_reg[i*8 +: 8]))
                hit = 1'b0;
        end
    end

    always_comb
    begin
        window_next = window_reg;
        count_next  = count_reg;
        cmd.bytes   = w;
        cmd.n       = 4'd0;
        cmd.last    = item.last_in;
        if (full_now && hit)
        begin
            cmd.bytes  = replacement_bytes_reg;
            cmd.n      = rlen_eff;
            count_next = 3'd0;
        end
        else if (full_now)
        begin
            // miss: oldest byte goes out, whole window on the last beat
            cmd.n       = item.last_in ? len_eff : 4'd1;
            window_next = w >> 8;
            count_next  = 3'(len_eff - 4'd1);
        end
        else
        begin
            cmd.n       = item.last_in ? count_inc : 4'd0;
            window_next = w;
            count_next  = count_inc[2:0];
        end
        if (item.last_in)
            count_next = 3'd0;
    end

    // items that emit nothing stay out of the queue
    assign cmd_push = accept && ((cmd.n != 4'd0) || item.last_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_length_reg       <= 4'd1;
            match_pattern_reg      <= 64'd0;
            replacement_length_reg <= 4'd0;
            replacement_bytes_reg  <= 64'd0;
            count_reg              <= 3'd0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_MATCH_LENGTH:       match_length_reg       <= cfg_data[3:0];
                    REG_MATCH_PATTERN:      match_pattern_reg      <= cfg_data;
                    REG_REPLACEMENT_LENGTH: replacement_length_reg <= cfg_data[3:0];
                    REG_REPLACEMENT_BYTES:  replacement_bytes_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cfg_wen && (cfg_index == REG_MATCH_LENGTH))
                count_reg <= 3'd0;
            else if (accept)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            window_reg <= window_next;
    end

endmodule

`default_nettype wire

FILE: hdl/bpr_cmd_fifo.sv
// bpr_cmd_fifo: short command queue between front and back
// depends on bpr_pkg for cmd_t and CMD_DEPTH
`default_nettype none

module bpr_cmd_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr,
    input  wire bpr_pkg::cmd_t wr_cmd,
    input  wire logic          rd,
    output bpr_pkg::cmd_t      rd_cmd,
    output logic               full,
    output logic               empty
);
    import bpr_pkg::*;

    localparam int PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CW = $clog2(CMD_DEPTH + 1);

    cmd_t          mem [CMD_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg;

    assign full   = (cnt_reg == CW'(CMD_DEPTH));
    assign empty  = (cnt_reg == CW'(0));
    assign rd_cmd = mem[rp_reg];

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        if (p == PW'(CMD_DEPTH - 1))
            return PW'(0);
        return p + PW'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= bump(wp_reg);
            if (rd)
                rp_reg <= bump(rp_reg);
            if (wr && !rd)
                cnt_reg <= cnt_reg + CW'(1);
            else if (rd && !wr)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wr_cmd;
    end

endmodule

`default_nettype wire

FILE: hdl/bpr_back.sv
// bpr_back: walks each command one byte a cycle into the result register while pop keeps up
// depends on bpr_pkg; reads from bpr_cmd_fifo
`default_nettype none

module bpr_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bpr_pkg::cmd_t head,
    input  wire logic          cmd_empty,
    output logic               cmd_pop,
    input  wire logic          pop,
    output logic               empty,
    output bpr_pkg::out_item_t result
);
    import bpr_pkg::*;

    logic      busy_reg, busy_next;
    cmd_t      cur_reg;
    logic [2:0] idx_reg, idx_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg;

    logic [3:0] items;
    logic       fin;
    logic       adv;
    logic       emit;
    logic       load;
    out_item_t  item_now;

    assign adv   = !out_valid_reg || pop;
    // an empty command still sends the end marker
    assign items = (cur_reg.n == 4'd0) ? 4'd1 : cur_reg.n;
    assign fin   = ({1'b0, idx_reg} == (items - 4'd1));
    assign emit  = busy_reg && adv;
    assign load  = !busy_reg || (emit && fin);
    assign cmd_pop = load && !cmd_empty;

    always_comb
    begin
        item_now.byte_valid = (cur_reg.n != 4'd0);
        item_now.out_byte   = item_now.byte_valid ? cur_reg.bytes[idx_reg*8 +: 8] : 8'd0;
        item_now.last_out   = cur_reg.last && fin;
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = !cmd_empty;
            idx_next  = 3'd0;
        end
        else if (emit)
            idx_next = idx_reg + 3'd1;
        if (emit)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
            cur_reg <= head;
        if (emit)
            out_reg <= item_now;
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

`default_nettype wire

FILE: hdl/byte_pattern_replace.sv
// byte_pattern_replace: top level, front classifier, command queue, back emitter
// depends on bpr_pkg, bpr_front, bpr_cmd_fifo, bpr_back
//
//   channel   handshake        payload
//   input     push / full      item   (data_byte, last_in)
//   result    empty / pop      result (out_byte, byte_valid, last_out)
//   config    cfg_wen          cfg_index, cfg_data
//
// a byte is taken every cycle while the two-entry command queue has room
// the back emitter sends one result beat per cycle while pop keeps up; a match
// or a flush of n bytes holds it until all n are sent, so the queue can fill and
// raise full; bytes that only fill the window produce no beat
// reset clears the window fill, queue and result valid flag; no clearing pass
`default_nettype none

module byte_pattern_replace (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire bpr_pkg::in_item_t  item,
    output logic                    empty,
    input  wire logic               pop,
    output bpr_pkg::out_item_t      result,
    input  wire logic               cfg_wen,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [63:0]        cfg_data
);
    import bpr_pkg::*;

    logic accept;
    logic cmd_push;
    logic cmd_pop;
    logic cmd_full;
    logic cmd_empty;
    cmd_t cmd_in;
    cmd_t cmd_head;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    bpr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (item),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    bpr_cmd_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (cmd_push),
        .wr_cmd (cmd_in),
        .rd     (cmd_pop),
        .rd_cmd (cmd_head),
        .full   (cmd_full),
        .empty  (cmd_empty)
    );

    bpr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (cmd_head),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

`ifndef ASSERT_OFF
    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.byte_valid) |-> (result.out_byte == 8'd0 && result.last_out))
        else $error("end marker beat malformed");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command queue read while empty");
`endif

endmodule

`default_nettype wire

FILE: bench/byte_pattern_replace_test.sv
// byte_pattern_replace_test: self-checking bench for the byte pattern replace block
// drives byte beats through push/full, checks result beats on empty/pop against a
// built-in predictor of the window logic; depends on bpr_pkg and byte_pattern_replace
module byte_pattern_replace_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bpr_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    in_item_t    item = '0;
    logic        empty;
    logic        pop = 1'b0;
    out_item_t   result;
    logic        cfg_wen = 1'b0;
    logic [1:0]  cfg_index = REG_MATCH_LENGTH;
    logic [63:0] cfg_data = '0;

    byte_pattern_replace dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor copy of the registers and the match window
    logic [3:0]  cfg_match_len = 4'd1;
    logic [63:0] cfg_pattern = '0;
    logic [3:0]  cfg_rep_len = 4'd0;
    logic [63:0] cfg_rep_bytes = '0;
    logic [7:0]  win_bytes [8];
    int          win_fill = 0;

    in_item_t    byte_backlog [$];
    out_item_t   expected_beats [$];

    bit gaps_on = 1'b1;
    int errors = 0;
    int bytes_sent = 0;
    int beats_checked = 0;
    int settings_used = 0;
    int stalls_done = 0;

    function automatic int active_match_len();
        if (cfg_match_len == 4'd0)
            return 1;
        if (cfg_match_len > MAX_PATTERN)
            return MAX_PATTERN;
        return int'(cfg_match_len);
    endfunction

    function automatic int active_rep_len();
        if (cfg_rep_len > MAX_REPLACE)
            return MAX_REPLACE;
        return int'(cfg_rep_len);
    endfunction

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic expect_beat(input logic [7:0] b, input logic valid);
        out_item_t beat;
        beat.out_byte = b;
        beat.byte_valid = valid;
        beat.last_out = 1'b0;
        expected_beats.push_back(beat);
    endtask

    // window update for one accepted byte beat
    task automatic replace_step(input in_item_t it);
        int mlen;
        int rlen;
        int made;
        logic hit;
        out_item_t beat;
        mlen = active_match_len();
        rlen = active_rep_len();
        made = 0;
        if (win_fill >= mlen)
            win_fill = 0;
        win_bytes[win_fill] = it.data_byte;
        win_fill++;
        if (win_fill == mlen)
        begin
            hit = 1'b1;
            for (int i = 0; i < mlen; i++)
                if (win_bytes[i] != cfg_pattern[8*i +: 8])
                    hit = 1'b0;
            if (hit)
            begin
                for (int i = 0; i < rlen; i++)
                begin
                    expect_beat(cfg_rep_bytes[8*i +: 8], 1'b1);
                    made++;
                end
                win_fill = 0;
            end
            else
            begin
                expect_beat(win_bytes[0], 1'b1);
                made++;
                for (int i = 1; i < win_fill; i++)
                    win_bytes[i-1] = win_bytes[i];
                win_fill--;
            end
        end
        if (it.last_in)
        begin
            for (int i = 0; i < win_fill; i++)
            begin
                expect_beat(win_bytes[i], 1'b1);
                made++;
            end
            win_fill = 0;
            // nothing left to emit: empty end marker
            if (made == 0)
                expect_beat(8'h00, 1'b0);
            beat = expected_beats.pop_back();
            beat.last_out = 1'b1;
            expected_beats.push_back(beat);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            REG_MATCH_LENGTH:
            begin
                cfg_match_len = data[3:0];
                win_fill = 0;
            end
            REG_MATCH_PATTERN:      cfg_pattern = data;
            REG_REPLACEMENT_LENGTH: cfg_rep_len = data[3:0];
            REG_REPLACEMENT_BYTES:  cfg_rep_bytes = data;
            default: ;
        endcase
    endtask

    task automatic add_byte(input logic [7:0] b, input logic last);
        in_item_t it;
        it.data_byte = b;
        it.last_in = last;
        byte_backlog.push_back(it);
    endtask

    // wait until every byte is taken and every beat is back, then let the block drain
    task automatic settle();
        while (byte_backlog.size() != 0 || push || expected_beats.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // pattern copies, pattern fragments and single pattern bytes, the rest random noise
    task automatic queue_streams(input int target, input bit end_open);
        int made;
        int plen;
        int chunk;
        int r;
        logic [7:0] b;
        made = 0;
        while (made < target)
        begin
            plen = active_match_len();
            r = $urandom_range(0, 99);
            if (r < 35)
                chunk = plen;
            else if (r < 50)
                chunk = (plen > 1) ? $urandom_range(1, plen - 1) : 1;
            else
                chunk = 1;
            for (int k = 0; k < chunk && made < target; k++)
            begin
                if (r < 50)
                    b = cfg_pattern[8*k +: 8];
                else if (r < 85)
                    b = cfg_pattern[8*$urandom_range(0, plen - 1) +: 8];
                else
                    b = 8'($urandom);
                made++;
                if (made == target)
                    add_byte(b, !end_open);
                else
                    add_byte(b, $urandom_range(0, 11) == 0);
            end
        end
    endtask

    // sender: byte beats from the backlog, random gaps between them
    int send_wait = 0;
    always @(posedge clk)
    begin
        logic take;
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            take = push && !full;
            if (take)
            begin
                replace_step(item);
                bytes_sent++;
                send_wait = pick_gap();
            end
            if (push && !take)
                ;
            else if (send_wait > 0)
            begin
                send_wait--;
                push <= 1'b0;
            end
            else if (byte_backlog.size() != 0)
            begin
                push <= 1'b1;
                item <= byte_backlog.pop_front();
            end
            else
                push <= 1'b0;
        end
    end

    // receiver: checks each result beat, random gaps and a couple of long holds
    int pop_wait = 0;
    int stall_left = 0;
    int stall_mark = 40;
    always @(posedge clk)
    begin
        out_item_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: unexpected result beat byte %02h valid %0b last %0b",
                             $time, result.out_byte, result.byte_valid, result.last_out);
                    errors++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (result.out_byte !== want.out_byte)
                    begin
                        $display("%0t: beat %0d out_byte expected %02h actual %02h",
                                 $time, beats_checked, want.out_byte, result.out_byte);
                        errors++;
                    end
                    if (result.byte_valid !== want.byte_valid)
                    begin
                        $display("%0t: beat %0d byte_valid expected %0b actual %0b",
                                 $time, beats_checked, want.byte_valid, result.byte_valid);
                        errors++;
                    end
                    if (result.last_out !== want.last_out)
                    begin
                        $display("%0t: beat %0d last_out expected %0b actual %0b",
                                 $time, beats_checked, want.last_out, result.last_out);
                        errors++;
                    end
                end
                beats_checked++;
                pop_wait = pick_gap();
            end
            // long hold while bytes keep coming, so the block backs up to full
            if (stalls_done < 2 && stall_left == 0 && beats_checked >= stall_mark
                && byte_backlog.size() > 10)
            begin
                stall_left = 300;
                stalls_done++;
                stall_mark = beats_checked + 150;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (pop_wait > 0)
            begin
                pop_wait--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        logic [63:0] d;
        int spin;
        for (int i = 0; i < 8; i++)
            win_bytes[i] = 8'h00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // three-byte pattern, two-byte replacement, overlap and flush on last
        write_reg(REG_MATCH_LENGTH, 64'd3);
        write_reg(REG_MATCH_PATTERN, 64'h0000_0000_0043_4241);
        write_reg(REG_REPLACEMENT_LENGTH, 64'd2);
        write_reg(REG_REPLACEMENT_BYTES, 64'h0000_0000_0000_ff00);
        settings_used++;
        add_byte(8'h41, 1'b0);
        add_byte(8'h42, 1'b0);
        add_byte(8'h43, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'h42, 1'b0);
        add_byte(8'h43, 1'b0);
        add_byte(8'hff, 1'b0);
        add_byte(8'h00, 1'b1);
        settle();

        // zero match length acts as one, oversized replacement length acts as eight
        write_reg(REG_MATCH_LENGTH, 64'hffff_ffff_ffff_fff0);
        write_reg(REG_MATCH_PATTERN, 64'h0000_0000_0000_005a);
        write_reg(REG_REPLACEMENT_LENGTH, 64'h0000_0000_0000_000f);
        write_reg(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
        settings_used++;
        add_byte(8'h5a, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h5a, 1'b1);
        settle();

        // oversized match length acts as eight; empty replacement gives the end marker
        write_reg(REG_MATCH_LENGTH, 64'h0000_0000_0000_000f);
        write_reg(REG_MATCH_PATTERN, 64'h0807_0605_0403_0201);
        write_reg(REG_REPLACEMENT_LENGTH, 64'd0);
        settings_used++;
        for (int i = 1; i <= 8; i++)
            add_byte(8'(i), i == 8);
        add_byte(8'haa, 1'b1);
        add_byte(8'h01, 1'b0);
        add_byte(8'h02, 1'b0);
        settle();
        // new match length drops the two bytes held in the window
        write_reg(REG_MATCH_LENGTH, 64'd2);
        settings_used++;
        add_byte(8'h01, 1'b0);
        add_byte(8'h02, 1'b1);
        settle();

        for (int phase = 0; phase < 6; phase++)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if (phase == 0 || $urandom_range(0, 9) < 7)
            begin
                d = {$urandom, $urandom};
                case ($urandom_range(0, 5))
                    0: d[3:0] = 4'd1;
                    1: d[3:0] = 4'd8;
                    2: d[3:0] = 4'd0;
                    3: d[3:0] = 4'($urandom_range(9, 15));
                    default: d[3:0] = 4'($urandom_range(2, 7));
                endcase
                write_reg(REG_MATCH_LENGTH, d);
            end
            d = {$urandom, $urandom};
            // two-symbol patterns make self-overlapping matches likely
            if ($urandom_range(0, 1) == 1)
                for (int i = 0; i < 8; i++)
                    d[8*i +: 8] = ($urandom_range(0, 2) == 0) ? 8'h3c : 8'hc3;
            write_reg(REG_MATCH_PATTERN, d);
            d = {$urandom, $urandom};
            case ($urandom_range(0, 4))
                0: d[3:0] = 4'd0;
                1: d[3:0] = 4'd8;
                2: d[3:0] = 4'($urandom_range(9, 15));
                default: d[3:0] = 4'($urandom_range(1, 7));
            endcase
            write_reg(REG_REPLACEMENT_LENGTH, d);
            write_reg(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
            settings_used++;
            queue_streams((phase == 0) ? 60 : 28, $urandom_range(0, 1) == 1);
            settle();
        end

        spin = 0;
        while ((byte_backlog.size() != 0 || push || expected_beats.size() != 0)
               && spin < 200000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (20) @(posedge clk);
        if (expected_beats.size() != 0)
        begin
            $display("%0t: %0d expected result beats never arrived",
                     $time, expected_beats.size());
            errors += expected_beats.size();
        end

        $display("run covered %0d byte beats under %0d register settings",
                 bytes_sent, settings_used);
        $display("%0d result beats checked, %0d long receiver holds, %0d errors",
                 beats_checked, stalls_done, errors);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
